@@ hdl/rzs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rzs_pkg
// Shared widths, codes and types of the rolling z-score signal block.
// ----------------------------------------------------------------------------
package rzs_pkg;

  localparam int DEF_MAX_WINDOW = 64;

  localparam int PRICE_W = 24;
  localparam int SHARE_W = 32;
  localparam int CASH_W  = 40;
  localparam int QTY_W   = 40;
  localparam int N_W     = 7;
  localparam int THR_W   = 12;
  localparam int CFG_W   = 12;
  localparam int ACT_W   = 2;

  // The window length register limits N to 127, so the sums have fixed widths.
  localparam int SUM_W  = PRICE_W + N_W;
  localparam int SQ_W   = 2 * PRICE_W + N_W;
  localparam int V_W    = 2 * SUM_W;
  localparam int TT_W   = 2 * THR_W;
  localparam int HALF_W = V_W / 2;
  localparam int PP_W   = HALF_W + TT_W;
  localparam int LHS_W  = V_W + 16;
  localparam int RHS_W  = V_W + TT_W;
  localparam int DCNT_W = $clog2(QTY_W + 1);

  localparam logic [0:0] REG_WINDOW    = 1'b0;
  localparam logic [0:0] REG_THRESHOLD = 1'b1;

  localparam logic [N_W-1:0]   RST_WINDOW    = N_W'(20);
  localparam logic [THR_W-1:0] RST_THRESHOLD = THR_W'(512);

  typedef enum logic [ACT_W-1:0] {
    ACT_HOLD = 2'd0,
    ACT_BUY  = 2'd1,
    ACT_SELL = 2'd2
  } action_t;

  typedef enum logic {
    F_IDLE,
    F_UPD
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_M1,
    B_M2,
    B_M3,
    B_M4,
    B_CMP,
    B_DIV,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic [PRICE_W-1:0] close;
    logic [SHARE_W-1:0] shares;
    logic [CASH_W-1:0]  cash;
    logic [N_W-1:0]     n;
    logic [SUM_W-1:0]   sum;
    logic [SQ_W-1:0]    sumsq;
    logic               warm;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

@@ hdl/rzs_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rzs_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rzs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/rzs_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rzs_fifo
// Two-entry queue between the window front end and the decision back end.
// ----------------------------------------------------------------------------
module rzs_fifo #(
  parameter int WIDTH = 8
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire [WIDTH-1:0]  push_data,
  output logic             full,
  input  wire              pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

@@ hdl/rzs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rzs_front
// Accepts bars, keeps the price ring and the running sums, queues each bar.
// ----------------------------------------------------------------------------
module rzs_front #(
  parameter int MAX_WINDOW = rzs_pkg::DEF_MAX_WINDOW
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          clear,
  input  wire [rzs_pkg::N_W-1:0]       n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [rzs_pkg::PRICE_W-1:0]   close_price,
  input  wire [rzs_pkg::SHARE_W-1:0]   held_shares,
  input  wire [rzs_pkg::CASH_W-1:0]    cash_available,
  output logic                         push,
  output rzs_pkg::entry_t              push_data,
  input  wire                          q_full
);
  import rzs_pkg::*;

  localparam int SLOT_W = $clog2(MAX_WINDOW);

  front_state_t       state;
  front_state_t       state_next;
  logic [PRICE_W-1:0] close;
  logic [SHARE_W-1:0] shares;
  logic [CASH_W-1:0]  cash;
  logic [SLOT_W-1:0]  write_slot;
  logic [N_W-1:0]     bars_seen;
  logic [SUM_W-1:0]   window_sum;
  logic [SQ_W-1:0]    window_square_sum;
  logic [PRICE_W-1:0] old_price;
  logic               full_win;
  logic [PRICE_W-1:0] drop;
  logic [SUM_W-1:0]   sum_next;
  logic [SQ_W-1:0]    sq_next;
  logic [N_W-1:0]     bars_next;
  logic [SLOT_W-1:0]  slot_next;
  logic               accept;
  logic               upd;

  rzs_ram #(.WIDTH(PRICE_W), .DEPTH(MAX_WINDOW)) u_ring (
    .clk   (clk),
    .we    (upd),
    .waddr (write_slot),
    .wdata (close),
    .raddr (write_slot),
    .rdata (old_price)
  );

  assign accept   = in_valid && in_ready;
  assign upd      = (state == F_UPD);
  assign full_win = (bars_seen >= n);
  assign drop     = full_win ? old_price : '0;
  assign sum_next = window_sum - SUM_W'(drop) + SUM_W'(close);
  assign sq_next  = window_square_sum - SQ_W'(drop * drop) + SQ_W'(close * close);
  assign bars_next = full_win ? bars_seen : bars_seen + N_W'(1);
  assign slot_next = ((N_W + 1)'(write_slot) + (N_W + 1)'(1) >= (N_W + 1)'(n))
                     ? '0 : write_slot + SLOT_W'(1);

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      F_IDLE: begin
        in_ready = !q_full;
        if (accept) begin
          state_next = F_UPD;
        end
      end
      F_UPD: begin
        state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  assign push             = upd;
  assign push_data.close  = close;
  assign push_data.shares = shares;
  assign push_data.cash   = cash;
  assign push_data.n      = n;
  assign push_data.sum    = sum_next;
  assign push_data.sumsq  = sq_next;
  assign push_data.warm   = (bars_next < n);

  always_ff @(posedge clk) begin
    if (accept) begin
      close  <= close_price;
      shares <= held_shares;
      cash   <= cash_available;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= F_IDLE;
      write_slot        <= '0;
      bars_seen         <= '0;
      window_sum        <= '0;
      window_square_sum <= '0;
    end else begin
      state <= state_next;
      if (clear) begin
        write_slot        <= '0;
        bars_seen         <= '0;
        window_sum        <= '0;
        window_square_sum <= '0;
      end else if (upd) begin
        write_slot        <= slot_next;
        bars_seen         <= bars_next;
        window_sum        <= sum_next;
        window_square_sum <= sq_next;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/rzs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rzs_back
// Forms the exact z-score test, the trade decision and the buy quantity.
// ----------------------------------------------------------------------------
module rzs_back (
  input  wire                         clk,
  input  wire                         rst,
  input  wire [rzs_pkg::THR_W-1:0]    z_threshold,
  input  wire                         q_empty,
  input  rzs_pkg::entry_t             q_data,
  output logic                        pop,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [rzs_pkg::ACT_W-1:0]   action,
  output logic [rzs_pkg::PRICE_W-1:0] order_price,
  output logic [rzs_pkg::QTY_W-1:0]   order_quantity,
  output logic                        warming_up
);
  import rzs_pkg::*;

  back_state_t        state;
  back_state_t        state_next;
  entry_t             e;
  logic [SUM_W-1:0]   nclose;
  logic [V_W-1:0]     nsq;
  logic [V_W-1:0]     sum2;
  logic [V_W-1:0]     v;
  logic [SUM_W-1:0]   mag;
  logic               neg;
  logic [TT_W-1:0]    tt;
  logic [V_W-1:0]     d2;
  logic [PP_W-1:0]    plo;
  logic [PP_W-1:0]    phi;
  logic [LHS_W-1:0]   lhs;
  logic [RHS_W-1:0]   rhs;
  logic               zero_case;
  action_t            act;
  logic [QTY_W-1:0]   qty;
  logic [PRICE_W:0]   rem;
  logic [DCNT_W-1:0]  dcnt;
  logic               beyond;
  logic               do_buy;
  logic               do_sell;
  logic [PRICE_W:0]   trial_in;
  logic [PRICE_W+1:0] trial;
  logic               out_free;

  assign out_free = !out_valid || out_ready;
  assign beyond   = !zero_case && ({{(RHS_W - LHS_W){1'b0}}, lhs} > rhs);
  assign do_buy   = beyond && neg && (e.shares == '0);
  assign do_sell  = beyond && !neg && (e.shares != '0);
  assign trial_in = {rem[PRICE_W-1:0], qty[QTY_W-1]};
  assign trial    = {1'b0, trial_in} - {2'b00, e.close};

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = B_M1;
        end
      end
      B_M1:  state_next = e.warm ? B_DONE : B_M2;
      B_M2:  state_next = B_M3;
      B_M3:  state_next = B_M4;
      B_M4:  state_next = B_CMP;
      B_CMP: state_next = (do_buy && e.close != '0) ? B_DIV : B_DONE;
      B_DIV: state_next = (dcnt == DCNT_W'(1)) ? B_DONE : B_DIV;
      B_DONE: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        e   <= q_data;
        act <= ACT_HOLD;
        qty <= '0;
      end
      B_M1: begin
        nclose <= SUM_W'(e.n * e.close);
        nsq    <= V_W'(e.n * e.sumsq);
        sum2   <= V_W'(e.sum * e.sum);
        tt     <= TT_W'(z_threshold * z_threshold);
      end
      B_M2: begin
        v   <= nsq - sum2;
        neg <= (nclose < e.sum);
        mag <= (nclose < e.sum) ? e.sum - nclose : nclose - e.sum;
      end
      B_M3: begin
        d2        <= V_W'(mag * mag);
        plo       <= PP_W'(v[HALF_W-1:0] * tt);
        phi       <= PP_W'(v[V_W-1:HALF_W] * tt);
        zero_case <= (v == '0) || (mag == '0);
      end
      B_M4: begin
        lhs <= {d2, 16'b0};
        rhs <= {phi, {HALF_W{1'b0}}} + RHS_W'(plo);
      end
      B_CMP: begin
        rem  <= '0;
        dcnt <= DCNT_W'(QTY_W);
        if (do_buy) begin
          act <= ACT_BUY;
          // A zero price saturates the quantity; otherwise the divider fills it.
          qty <= (e.close == '0) ? '1 : e.cash;
        end else if (do_sell) begin
          act <= ACT_SELL;
          qty <= QTY_W'(e.shares);
        end
      end
      B_DIV: begin
        dcnt <= dcnt - DCNT_W'(1);
        if (!trial[PRICE_W+1]) begin
          rem <= trial[PRICE_W:0];
          qty <= {qty[QTY_W-2:0], 1'b1};
        end else begin
          rem <= trial_in;
          qty <= {qty[QTY_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == B_DONE && out_free) begin
      action         <= act;
      order_price    <= (act == ACT_HOLD) ? '0 : e.close;
      order_quantity <= qty;
      warming_up     <= e.warm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/rolling_zscore_signal.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rolling_zscore_signal
// Rolling z-score mean-reversion signal on a stream of Q16.8 closing prices.
// ----------------------------------------------------------------------------
// One input beat carries a closing price, the held position and the cash;
// one output beat carries the action, order price, quantity and warm-up flag.
// Both channels use valid/ready. The configuration port writes the window
// length (index 0, also restarts the window) or the threshold (index 1).
// The user must write it only while the block is idle; the block does not
// enforce this. The front end takes a new bar once the last is queued and
// the queue has room: in its idle state the ring read fetches the price that
// leaves the window; its update state updates the sums and queues the bar.
// The back end pops and decodes a bar; a warm-up bar goes straight to output,
// any other bar passes the multiply stages and the compare, and a buy at a
// nonzero price adds the bit-serial cash/price division before output.
// A two-entry queue lets the front end keep taking bars while the back end
// works or the receiver stalls; a held output beat stays in the output
// register until taken, and the back end then waits.
// Reset empties the window and restores a length of 20 and threshold 512.
// ----------------------------------------------------------------------------
module rolling_zscore_signal #(
  parameter int MAX_WINDOW = rzs_pkg::DEF_MAX_WINDOW
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_write,
  input  wire [0:0]                   cfg_index,
  input  wire [rzs_pkg::CFG_W-1:0]    cfg_data,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire [rzs_pkg::PRICE_W-1:0]  close_price,
  input  wire [rzs_pkg::SHARE_W-1:0]  held_shares,
  input  wire [rzs_pkg::CASH_W-1:0]   cash_available,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [rzs_pkg::ACT_W-1:0]   action,
  output logic [rzs_pkg::PRICE_W-1:0] order_price,
  output logic [rzs_pkg::QTY_W-1:0]   order_quantity,
  output logic                        warming_up
);
  import rzs_pkg::*;

  logic [N_W-1:0]   window_length;
  logic [THR_W-1:0] z_threshold;
  logic [N_W-1:0]   n;
  logic             clear;
  logic             push;
  entry_t           push_data;
  logic             q_full;
  logic             pop;
  logic [ENTRY_W-1:0] q_raw;
  logic             q_empty;

  // A zero length acts as one; a length beyond the ring acts as the ring size.
  assign n = (window_length == '0) ? N_W'(1)
           : (int'(window_length) > MAX_WINDOW) ? N_W'(MAX_WINDOW) : window_length;
  assign clear = cfg_write && (cfg_index == REG_WINDOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= RST_WINDOW;
      z_threshold   <= RST_THRESHOLD;
    end else if (cfg_write) begin
      if (cfg_index == REG_WINDOW) begin
        window_length <= cfg_data[N_W-1:0];
      end else begin
        z_threshold <= cfg_data[THR_W-1:0];
      end
    end
  end

  rzs_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
    .clk            (clk),
    .rst            (rst),
    .clear          (clear),
    .n              (n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .close_price    (close_price),
    .held_shares    (held_shares),
    .cash_available (cash_available),
    .push           (push),
    .push_data      (push_data),
    .q_full         (q_full)
  );

  rzs_fifo #(.WIDTH(ENTRY_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_raw),
    .empty     (q_empty)
  );

  rzs_back u_back (
    .clk            (clk),
    .rst            (rst),
    .z_threshold    (z_threshold),
    .q_empty        (q_empty),
    .q_data         (entry_t'(q_raw)),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .action         (action),
    .order_price    (order_price),
    .order_quantity (order_quantity),
    .warming_up     (warming_up)
  );

endmodule
`default_nettype wire

@@ tb/sv/rolling_zscore_signal_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_zscore_signal_test
// Self-checking bench: bars go in over valid/ready and an in-bench predictor
// of the rolling sums and z-score decision checks every output beat.
// ----------------------------------------------------------------------------
module rolling_zscore_signal_test;
  import rzs_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    action_t            act;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic               warm;
  } signal_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [0:0]         cfg_index = REG_WINDOW;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  wire                in_ready;
  logic [PRICE_W-1:0] close_price = '0;
  logic [SHARE_W-1:0] held_shares = '0;
  logic [CASH_W-1:0]  cash_available = '0;
  wire                out_valid;
  logic               out_ready = 1'b0;
  wire [ACT_W-1:0]    action;
  wire [PRICE_W-1:0]  order_price;
  wire [QTY_W-1:0]    order_quantity;
  wire                warming_up;

  rolling_zscore_signal u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .close_price(close_price), .held_shares(held_shares),
    .cash_available(cash_available),
    .out_valid(out_valid), .out_ready(out_ready),
    .action(action), .order_price(order_price),
    .order_quantity(order_quantity), .warming_up(warming_up)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [PRICE_W-1:0] hist_ring [DEF_MAX_WINDOW];
  int unsigned        hist_slot, hist_count;
  logic [63:0]        run_sum, run_sq;
  logic [N_W-1:0]     win_len;
  logic [THR_W-1:0]   z_thr;

  signal_t     signal_q[$];
  int unsigned idle_pct, stall_pct;
  int unsigned mismatches, bars_sent, beats_seen, buys_seen, sells_seen;
  int unsigned quiet_cycles;

  task automatic predict_signal(input logic [PRICE_W-1:0] c, input logic [SHARE_W-1:0] s,
                                input logic [CASH_W-1:0] m);
    int unsigned  n, k;
    logic [63:0]  old, nc, mag;
    logic [127:0] v, lhs, rhs;
    logic         neg;
    signal_t      e;
    n = (win_len == 0) ? 1 : (win_len > DEF_MAX_WINDOW) ? DEF_MAX_WINDOW : win_len;
    k = hist_slot % n;
    e.act = ACT_HOLD; e.price = '0; e.qty = '0; e.warm = 1'b0;
    if (hist_count >= n) begin
      old = 64'(hist_ring[k]);
      run_sum -= old;
      run_sq  -= old * old;
    end
    hist_ring[k] = c;
    run_sum += 64'(c);
    run_sq  += 64'(c) * 64'(c);
    hist_slot = (k + 1 >= n) ? 0 : k + 1;
    if (hist_count < n) hist_count++;
    if (hist_count < n) begin
      e.warm = 1'b1;
    end else begin
      nc  = 64'(n) * 64'(c);
      neg = nc < run_sum;
      mag = neg ? run_sum - nc : nc - run_sum;
      v   = 128'(n) * 128'(run_sq) - 128'(run_sum) * 128'(run_sum);
      if (v != 0 && mag != 0) begin
        lhs = (128'(mag) * 128'(mag)) << 16;
        rhs = v * (128'(z_thr) * 128'(z_thr));
        if (lhs > rhs && neg && s == 0) begin
          e.act = ACT_BUY; e.price = c;
          e.qty = (c == 0) ? '1 : m / CASH_W'(c);
        end else if (lhs > rhs && !neg && s != 0) begin
          e.act = ACT_SELL; e.price = c; e.qty = QTY_W'(s);
        end
      end
    end
    signal_q = {signal_q, e};
  endtask

  task automatic send_bar(input logic [PRICE_W-1:0] c, input logic [SHARE_W-1:0] s,
                          input logic [CASH_W-1:0] m);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    close_price    <= c;
    held_shares    <= s;
    cash_available <= m;
    do @(posedge clk); while (!in_ready);
    predict_signal(c, s, m);
    bars_sent++;
  endtask

  task automatic drain_signals();
    in_valid <= 1'b0;
    while (signal_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
    drain_signals();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_WINDOW) begin
      win_len = val[N_W-1:0];
      hist_slot = 0; hist_count = 0; run_sum = 0; run_sq = 0;
    end else begin
      z_thr = val[THR_W-1:0];
    end
  endtask

  // Short directed walk through warm-up, flat window, buy, sell, zero price.
  task automatic test_directed();
    idle_pct = 0; stall_pct = 0;
    send_bar(24'd1000, 32'd0, 40'd5000);
    send_bar(24'd1000, 32'd0, 40'd5000);
    write_reg(REG_WINDOW, 12'd2);
    write_reg(REG_THRESHOLD, 12'd0);
    send_bar(24'd100, 32'd0, 40'd1000);
    send_bar(24'd100, 32'd0, 40'd1000);
    send_bar(24'd50, 32'd0, 40'd1000);
    send_bar(24'd200, 32'd5, 40'd0);
    send_bar(24'd0, 32'd0, 40'hFF_FFFF_FFFF);
    send_bar(24'hFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
    send_bar(24'hFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
    send_bar(24'd1, 32'd0, 40'hFF_FFFF_FFFF);
    send_bar(24'hFF_FFFF, 32'd0, 40'hFF_FFFF_FFFF);
    send_bar(24'd1, 32'd7, 40'd0);
    write_reg(REG_THRESHOLD, 12'd4095);
    send_bar(24'd10, 32'd0, 40'd100);
    send_bar(24'hFF_FFFF, 32'd3, 40'd100);
    // A zero window register behaves as a window of one bar.
    write_reg(REG_WINDOW, 12'd0);
    write_reg(REG_THRESHOLD, 12'd0);
    send_bar(24'd300, 32'd0, 40'd900);
    send_bar(24'd5, 32'd1, 40'd900);
    drain_signals();
  endtask

  // Random bars around a per-phase base with occasional spikes and noise.
  task automatic test_random_phase(input logic [N_W-1:0] wl, input logic [THR_W-1:0] thr,
                                   input int unsigned count, input int unsigned mode);
    int          base, p;
    logic [31:0] s;
    logic [39:0] m;
    write_reg(REG_WINDOW, CFG_W'(wl));
    write_reg(REG_THRESHOLD, thr);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 81; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 81; end
      default: begin idle_pct = 8; stall_pct = 8; end
    endcase
    base = ($urandom_range(3) == 0) ? $urandom_range(24'hFF_FFFF) : $urandom_range(20000, 100);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        p = $urandom_range(24'hFF_FFFF);
      end else begin
        p = base + $urandom_range(64) - 32;
        if ($urandom_range(6) == 0) p = $urandom_range(1) ? p * 2 : p / 3;
        if ($urandom_range(40) == 0) p = 0;
      end
      if (p < 0) p = 0;
      if (p > 24'hFF_FFFF) p = 24'hFF_FFFF;
      s = $urandom_range(1) ? 32'd0 : $urandom;
      m = {$urandom, $urandom};
      send_bar(p[PRICE_W-1:0], s, m);
      if (i == count / 2 && mode == 1) drain_signals();
    end
    drain_signals();
  endtask

  task automatic test_random();
    test_random_phase(7'd5,   12'd512,  80, 0);
    test_random_phase(7'd127, 12'd300, 100, 1);
    test_random_phase(7'd3,   12'd128,  80, 2);
    test_random_phase(7'd64,  12'd4095, 90, 3);
    test_random_phase(7'd1,   12'd0,    40, 0);
    test_random_phase(7'd20,  12'd256,  90, 1);
    test_random_phase(7'd2,   12'd64,   80, 2);
    test_random_phase(7'd10,  12'd384,  90, 3);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    signal_t e;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("rolling_zscore_signal verification failed");
        $finish;
      end
      if (out_valid && out_ready) begin
        beats_seen++;
        if (signal_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected output beat act=%0d", action);
          mismatches++;
        end else begin
          e = signal_q.pop_front();
          if (action == ACT_BUY) buys_seen++;
          if (action == ACT_SELL) sells_seen++;
          if (action !== e.act || order_price !== e.price ||
              order_quantity !== e.qty || warming_up !== e.warm) begin
            if (mismatches < 10)
              $display("mismatch: exp act=%0d price=%0d qty=%0d warm=%0d, got %0d %0d %0d %0d",
                       e.act, e.price, e.qty, e.warm,
                       action, order_price, order_quantity, warming_up);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    idle_pct = 0; stall_pct = 0;
    mismatches = 0; bars_sent = 0; beats_seen = 0; buys_seen = 0; sells_seen = 0;
    quiet_cycles = 0;
    win_len = RST_WINDOW; z_thr = RST_THRESHOLD;
    hist_slot = 0; hist_count = 0; run_sum = 0; run_sq = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    drain_signals();
    repeat (60) @(posedge clk);
    if (signal_q.size() != 0) begin
      $display("%0d expected beats never arrived", signal_q.size());
      mismatches++;
    end
    $display("covered %0d bars, %0d output beats (%0d buys, %0d sells)",
             bars_sent, beats_seen, buys_seen, sells_seen);
    $display("windows 0..127 and thresholds 0..4095 under four idle/stall mixes");
    if (mismatches == 0) begin
      $display("rolling_zscore_signal verification clean");
    end else begin
      $display("rolling_zscore_signal verification failed");
    end
    $finish;
  end

endmodule
